>>> rtl/jas_pkg.sv
`timescale 1ns / 1ps
package jas_pkg;

  typedef struct packed {
    logic        operation;
    logic [7:0]  job_number;
    logic [9:0]  memory_need;
    logic [7:0]  device_need;
    logic [15:0] run_length;
    logic [1:0]  hold_class;
  } jas_in_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [7:0] job_id;
    logic [9:0] free_memory;
    logic       last;
  } jas_out_t;

  typedef enum logic [2:0] {
    OUT_HELD      = 3'd0,
    OUT_ADMITTED  = 3'd1,
    OUT_COMPLETED = 3'd2,
    OUT_BIG_MEM   = 3'd3,
    OUT_BIG_DEV   = 3'd4,
    OUT_BAD_CLASS = 3'd5,
    OUT_FULL      = 3'd6,
    OUT_EMPTY     = 3'd7
  } outcome_t;

  localparam logic       OP_ARRIVE = 1'b0;
  localparam logic       OP_FINISH = 1'b1;
  localparam logic [1:0] CLASS_SORTED = 2'd1;
  localparam logic [1:0] CLASS_FIFO   = 2'd2;
  localparam logic       REG_TOTAL_MEMORY  = 1'b0;
  localparam logic       REG_TOTAL_DEVICES = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FINISH_RD,
    ST_SORTED_CHK,
    ST_SORTED_POP,
    ST_FIFO_CHK,
    ST_FIFO_POP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic do_reject;   // single result from the decide checks
    logic do_fifo_push;
    logic start_search;
    logic search_step;
    logic shift_step;
    logic finish_pop;
    logic sorted_pop;
    logic fifo_pop;
    logic emit_done;
  } jas_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic is_finish;
    logic reject;
    logic is_sorted;
    logic search_done;
    logic shift_done;
    logic ready_empty;
    logic sorted_can;
    logic fifo_can;
    logic out_busy;
  } jas_stat_t;

endpackage

>>> rtl/jas_ctrl.sv
`timescale 1ns / 1ps
module jas_ctrl
  import jas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  jas_stat_t stat,
  output jas_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.out_busy) begin
          if (stat.is_finish) begin
            state_next = ST_FINISH_RD;
          end else if (stat.reject) begin
            cmd.do_reject = 1'b1;
            state_next = ST_IDLE;
          end else if (stat.is_sorted) begin
            cmd.start_search = 1'b1;
            state_next = ST_SEARCH;
          end else begin
            cmd.do_fifo_push = 1'b1;
            state_next = ST_SORTED_CHK;
          end
        end
      end
      ST_SEARCH: begin
        if (stat.search_done) begin
          state_next = ST_SHIFT;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (!stat.out_busy) begin
          cmd.shift_step = 1'b1;
          if (stat.shift_done) begin
            state_next = ST_SORTED_CHK;
          end
        end
      end
      ST_FINISH_RD: begin
        if (!stat.out_busy) begin
          cmd.finish_pop = 1'b1;
          state_next = stat.ready_empty ? ST_IDLE : ST_SORTED_CHK;
        end
      end
      ST_SORTED_CHK: begin
        if (!stat.out_busy) begin
          state_next = stat.sorted_can ? ST_SORTED_POP : ST_FIFO_CHK;
        end
      end
      ST_SORTED_POP: begin
        cmd.sorted_pop = 1'b1;
        state_next = ST_SORTED_CHK;
      end
      ST_FIFO_CHK: begin
        if (!stat.out_busy) begin
          state_next = stat.fifo_can ? ST_FIFO_POP : ST_EMIT;
        end
      end
      ST_FIFO_POP: begin
        cmd.fifo_pop = 1'b1;
        state_next = ST_FIFO_CHK;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit_done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_pop_after_chk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORTED_POP) |-> $past(state) == ST_SORTED_CHK)
    else $error("sorted pop without check");
  a_search_to_shift: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> ($past(state) == ST_SEARCH || $past(state) == ST_SHIFT))
    else $error("shift entered out of order");

endmodule

>>> rtl/jas_datapath.sv
`timescale 1ns / 1ps
module jas_datapath
  import jas_pkg::*;
#(
  parameter int HOLD_DEPTH  = 16,
  parameter int READY_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  jas_in_t   in_data,
  input  logic      cfg_valid,
  input  logic      cfg_index,
  input  logic      cfg_hi_zero,
  input  logic [9:0] cfg_data,
  input  jas_cmd_t  cmd,
  output jas_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output jas_out_t  out_data
);

  localparam int HW = $clog2(HOLD_DEPTH);
  localparam int RW = $clog2(READY_DEPTH);

  typedef struct packed {
    logic [7:0]  job;
    logic [9:0]  mem;
    logic [15:0] run;
  } sent_t;
  typedef struct packed {
    logic [7:0] job;
    logic [9:0] mem;
  } fent_t;

  logic [9:0] mem_limit;
  logic [7:0] dev_limit;
  jas_in_t    req;

  // Sorted queue is a row of registers so the insert shifts one slot a cycle while the output is not stalled.
  sent_t      sorted_q [HOLD_DEPTH];
  logic [HW:0] sorted_count;
  logic [HW:0] pos;
  logic [HW:0] shift_idx;

  fent_t      fifo_mem [HOLD_DEPTH];
  logic [HW-1:0] fifo_rd, fifo_wr;
  logic [HW:0] fifo_count;
  fent_t      fifo_head;

  fent_t      ready_mem [READY_DEPTH];
  logic [RW-1:0] ready_rd, ready_wr;
  logic [RW:0] ready_count;
  fent_t      ready_head;

  logic [9:0] used_memory;
  logic [9:0] free_now;
  logic       pend_last;
  jas_out_t   pend_data;

  logic [HW-1:0] fifo_rd_inc, fifo_wr_inc, fifo_rd_look;
  logic [RW-1:0] ready_rd_inc, ready_wr_inc;

  assign fifo_rd_inc  = (fifo_rd == HW'(HOLD_DEPTH - 1)) ? '0 : fifo_rd + 1'b1;
  assign fifo_wr_inc  = (fifo_wr == HW'(HOLD_DEPTH - 1)) ? '0 : fifo_wr + 1'b1;
  assign ready_rd_inc = (ready_rd == RW'(READY_DEPTH - 1)) ? '0 : ready_rd + 1'b1;
  assign ready_wr_inc = (ready_wr == RW'(READY_DEPTH - 1)) ? '0 : ready_wr + 1'b1;
  assign fifo_rd_look = cmd.fifo_pop ? fifo_rd_inc : fifo_rd;

  assign free_now = (used_memory >= mem_limit) ? 10'd0 : mem_limit - used_memory;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_limit <= '0;
      dev_limit <= '0;
    end else if (cfg_valid && cfg_hi_zero) begin
      if (cfg_index == REG_TOTAL_MEMORY) begin
        mem_limit <= cfg_data;
      end else begin
        dev_limit <= cfg_data[7:0];
      end
    end
  end

  // Read ports of the two memories are registered. A FIFO pop reads ahead to the
  // next entry so the head is current at the following check.
  always_ff @(posedge clk) begin
    fifo_head  <= fifo_mem[fifo_rd_look];
    ready_head <= ready_mem[ready_rd];
  end

  logic reject_any;
  outcome_t reject_code;
  logic hold_full;
  always_comb begin
    hold_full = (req.hold_class == CLASS_SORTED) ? (sorted_count >= (HW+1)'(HOLD_DEPTH))
                                                 : (fifo_count >= (HW+1)'(HOLD_DEPTH));
    reject_any = 1'b1;
    reject_code = OUT_FULL;
    if (req.memory_need > mem_limit) begin
      reject_code = OUT_BIG_MEM;
    end else if (req.device_need > dev_limit) begin
      reject_code = OUT_BIG_DEV;
    end else if (req.hold_class != CLASS_SORTED && req.hold_class != CLASS_FIFO) begin
      reject_code = OUT_BAD_CLASS;
    end else if (!hold_full) begin
      reject_any = 1'b0;
    end
  end

  logic ready_room;
  assign ready_room = ready_count < (RW+1)'(READY_DEPTH);

  always_comb begin
    stat.is_finish   = req.operation == OP_FINISH;
    stat.reject      = reject_any;
    stat.is_sorted   = req.hold_class == CLASS_SORTED;
    stat.search_done = (pos >= sorted_count) ||
                       (sorted_q[pos[HW-1:0]].run > req.run_length);
    stat.shift_done  = shift_idx == pos;
    stat.ready_empty = ready_count == '0;
    stat.sorted_can  = (sorted_count != '0) && ready_room && (sorted_q[0].mem <= free_now);
    stat.fifo_can    = (fifo_count != '0) && ready_room && (fifo_head.mem <= free_now);
    stat.out_busy    = out_valid && !out_ready;
  end

  logic    emit_en;
  outcome_t emit_code;
  logic [7:0] emit_id;
  logic [9:0] used_next;

  always_comb begin
    emit_en = 1'b0;
    emit_code = OUT_HELD;
    emit_id = req.job_number;
    used_next = used_memory;
    if (cmd.do_reject) begin
      emit_en = 1'b1;
      emit_code = reject_code;
    end else if (cmd.do_fifo_push || (cmd.shift_step && stat.shift_done)) begin
      emit_en = 1'b1;
    end else if (cmd.finish_pop) begin
      emit_en = 1'b1;
      if (stat.ready_empty) begin
        emit_code = OUT_EMPTY;
        emit_id = '0;
      end else begin
        emit_code = OUT_COMPLETED;
        emit_id = ready_head.job;
        used_next = (ready_head.mem >= used_memory) ? 10'd0 : used_memory - ready_head.mem;
      end
    end else if (cmd.sorted_pop) begin
      emit_en = 1'b1;
      emit_code = OUT_ADMITTED;
      emit_id = sorted_q[0].job;
      used_next = used_memory + sorted_q[0].mem;
    end else if (cmd.fifo_pop) begin
      emit_en = 1'b1;
      emit_code = OUT_ADMITTED;
      emit_id = fifo_head.job;
      used_next = used_memory + fifo_head.mem;
    end
  end

  logic [9:0] free_next;
  assign free_next = (used_next >= mem_limit) ? 10'd0 : mem_limit - used_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_count <= '0;
      fifo_count <= '0;
      fifo_rd <= '0;
      fifo_wr <= '0;
      ready_count <= '0;
      ready_rd <= '0;
      ready_wr <= '0;
      used_memory <= '0;
      out_valid <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      used_memory <= used_next;
      if (cmd.do_reject || (cmd.finish_pop && stat.ready_empty)) begin
        out_valid <= 1'b1;
        out_data <= '{emit_code, emit_id, free_next, 1'b1};
        pend_last <= 1'b0;
      end else if (cmd.emit_done) begin
        out_valid <= 1'b1;
        out_data <= '{pend_data.outcome, pend_data.job_id, pend_data.free_memory, 1'b1};
        pend_last <= 1'b0;
      end else if (emit_en) begin
        // A result is held back one step so the final one can carry last.
        if (pend_last) begin
          out_valid <= 1'b1;
          out_data <= pend_data;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
        pend_data <= '{emit_code, emit_id, free_next, 1'b0};
        pend_last <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.do_fifo_push) begin
        fifo_wr <= fifo_wr_inc;
        fifo_count <= fifo_count + 1'b1;
      end
      if (cmd.fifo_pop) begin
        fifo_rd <= fifo_rd_inc;
        fifo_count <= fifo_count - 1'b1;
      end
      if (cmd.finish_pop && !stat.ready_empty) begin
        ready_rd <= ready_rd_inc;
        ready_count <= ready_count - 1'b1;
      end
      if (cmd.sorted_pop || cmd.fifo_pop) begin
        ready_wr <= ready_wr_inc;
        ready_count <= ready_count + 1'b1;
      end
      if (cmd.shift_step && stat.shift_done) begin
        sorted_count <= sorted_count + 1'b1;
      end
      if (cmd.sorted_pop) begin
        sorted_count <= sorted_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req <= in_data;
    end
    if (cmd.start_search) begin
      pos <= '0;
      shift_idx <= sorted_count;
    end else if (cmd.search_step) begin
      pos <= pos + 1'b1;
    end
    if (cmd.shift_step) begin
      if (stat.shift_done) begin
        sorted_q[pos[HW-1:0]] <= '{req.job_number, req.memory_need, req.run_length};
      end else begin
        sorted_q[shift_idx[HW-1:0]] <= sorted_q[shift_idx[HW-1:0] - 1'b1];
        shift_idx <= shift_idx - 1'b1;
      end
    end
    if (cmd.sorted_pop) begin
      for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
        sorted_q[i] <= sorted_q[i+1];
      end
    end
    if (cmd.do_fifo_push) begin
      fifo_mem[fifo_wr] <= '{req.job_number, req.memory_need};
    end
    if (cmd.sorted_pop) begin
      ready_mem[ready_wr] <= '{sorted_q[0].job, sorted_q[0].mem};
    end else if (cmd.fifo_pop) begin
      ready_mem[ready_wr] <= fifo_head;
    end
  end

  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    sorted_count <= (HW+1)'(HOLD_DEPTH) && fifo_count <= (HW+1)'(HOLD_DEPTH))
    else $error("hold count overflow");
  a_ready_bound: assert property (@(posedge clk) disable iff (rst)
    ready_count <= (RW+1)'(READY_DEPTH)) else $error("ready count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

>>> rtl/job_admission_scheduler.sv
`timescale 1ns / 1ps
// Job admission engine. One request is worked at a time, and the input is not
// ready again until the request's last result has been produced. A rejection
// or a finish on an empty ready queue gives a single result. A held arrival
// or a finish then moves held jobs to the ready queue, sorted queue first,
// while memory and room allow. A class 1 arrival first searches past the
// jobs in the sorted queue that sort ahead, and the insert shifts the rest.
// Each result waits until the one before it has been taken, and the last
// result of a request carries last.
module job_admission_scheduler
  import jas_pkg::*;
#(
  parameter int HOLD_DEPTH  = 16,
  parameter int READY_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  jas_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output jas_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [9:0] cfg_data
);

  jas_cmd_t  cmd;
  jas_stat_t stat;

  assign cfg_ready = 1'b1;

  jas_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  jas_datapath #(.HOLD_DEPTH(HOLD_DEPTH), .READY_DEPTH(READY_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index[0]),
    .cfg_hi_zero(cfg_index[7:1] == 7'd0), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

>>> test/tb_job_admission_scheduler.sv
`timescale 1ns / 1ps
module tb_job_admission_scheduler;
  import jas_pkg::*;

  localparam int HOLD_DEPTH  = 16;
  localparam int READY_DEPTH = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [7:0] IDX_MEMORY  = 8'(REG_TOTAL_MEMORY);
  localparam logic [7:0] IDX_DEVICES = 8'(REG_TOTAL_DEVICES);
  localparam logic [7:0] IDX_UNUSED  = 8'd5;

  typedef struct packed {
    logic [7:0]  job;
    logic [9:0]  mem;
    logic [15:0] run;
  } job_entry_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_index;
  logic [9:0] cfg_data;
  jas_in_t  in_data;
  jas_out_t out_data;

  job_admission_scheduler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Scheduler copy kept by the testbench.
  logic [9:0]  sys_memory;
  logic [7:0]  sys_devices;
  job_entry_t  sorted_jobs [HOLD_DEPTH];
  job_entry_t  fifo_jobs [HOLD_DEPTH];
  job_entry_t  ready_jobs [READY_DEPTH];
  int          sorted_n, fifo_n, ready_n;
  logic [9:0]  mem_in_use;

  jas_in_t  pending_requests[$];
  jas_out_t predicted_results[$];

  int send_idle_pct, recv_idle_pct;
  int mismatches, stall_cycles;
  logic in_acc;

  function automatic logic [9:0] free_units();
    return (mem_in_use >= sys_memory) ? 10'd0 : sys_memory - mem_in_use;
  endfunction

  function automatic void add_result(outcome_t oc, logic [7:0] id);
    jas_out_t r;
    r.outcome = oc;
    r.job_id = id;
    r.free_memory = free_units();
    r.last = 1'b0;
    predicted_results.push_back(r);
  endfunction

  function automatic void admit_held();
    job_entry_t e;
    while (sorted_n > 0 && ready_n < READY_DEPTH && sorted_jobs[0].mem <= free_units()) begin
      e = sorted_jobs[0];
      for (int i = 0; i < sorted_n - 1; i++) sorted_jobs[i] = sorted_jobs[i+1];
      sorted_n--;
      ready_jobs[ready_n++] = e;
      mem_in_use = mem_in_use + e.mem;
      add_result(OUT_ADMITTED, e.job);
    end
    while (fifo_n > 0 && ready_n < READY_DEPTH && fifo_jobs[0].mem <= free_units()) begin
      e = fifo_jobs[0];
      for (int i = 0; i < fifo_n - 1; i++) fifo_jobs[i] = fifo_jobs[i+1];
      fifo_n--;
      ready_jobs[ready_n++] = e;
      mem_in_use = mem_in_use + e.mem;
      add_result(OUT_ADMITTED, e.job);
    end
  endfunction

  function automatic void schedule_job(jas_in_t rq);
    job_entry_t e;
    jas_out_t   tail;
    int         pos;
    if (rq.operation == OP_ARRIVE) begin
      if (rq.memory_need > sys_memory) add_result(OUT_BIG_MEM, rq.job_number);
      else if (rq.device_need > sys_devices) add_result(OUT_BIG_DEV, rq.job_number);
      else if (rq.hold_class != CLASS_SORTED && rq.hold_class != CLASS_FIFO)
        add_result(OUT_BAD_CLASS, rq.job_number);
      else if ((rq.hold_class == CLASS_SORTED ? sorted_n : fifo_n) >= HOLD_DEPTH)
        add_result(OUT_FULL, rq.job_number);
      else begin
        e.job = rq.job_number;
        e.mem = rq.memory_need;
        e.run = rq.run_length;
        if (rq.hold_class == CLASS_SORTED) begin
          pos = 0;
          while (pos < sorted_n && sorted_jobs[pos].run <= e.run) pos++;
          for (int i = sorted_n; i > pos; i--) sorted_jobs[i] = sorted_jobs[i-1];
          sorted_jobs[pos] = e;
          sorted_n++;
        end else begin
          e.run = '0;
          fifo_jobs[fifo_n++] = e;
        end
        add_result(OUT_HELD, rq.job_number);
        admit_held();
      end
    end else if (ready_n == 0) begin
      add_result(OUT_EMPTY, 8'd0);
    end else begin
      e = ready_jobs[0];
      for (int i = 0; i < ready_n - 1; i++) ready_jobs[i] = ready_jobs[i+1];
      ready_n--;
      mem_in_use = (e.mem >= mem_in_use) ? 10'd0 : mem_in_use - e.mem;
      add_result(OUT_COMPLETED, e.job);
      admit_held();
    end
    tail = predicted_results.pop_back();
    tail.last = 1'b1;
    predicted_results.push_back(tail);
  endfunction

  function automatic jas_in_t make_request(logic op, logic [7:0] job, logic [9:0] mem,
                                           logic [7:0] dev, logic [15:0] run,
                                           logic [1:0] cls);
    jas_in_t r;
    r.operation = op;
    r.job_number = job;
    r.memory_need = mem;
    r.device_need = dev;
    r.run_length = run;
    r.hold_class = cls;
    return r;
  endfunction

  // Mostly well-formed arrivals that fit, with finishes mixed in to keep jobs moving.
  function automatic jas_in_t random_request();
    jas_in_t r;
    int mem_cap;
    r = jas_in_t'({$urandom, $urandom});
    if ($urandom_range(99) < 35) begin
      r.operation = OP_FINISH;
      return r;
    end
    r.operation = OP_ARRIVE;
    mem_cap = (sys_memory / 3) + 1;
    if ($urandom_range(9) != 0) r.memory_need = 10'($urandom_range(mem_cap));
    if ($urandom_range(9) == 0) r.memory_need = '0;
    if ($urandom_range(9) != 0) r.device_need = 8'($urandom_range(int'(sys_devices)));
    if ($urandom_range(9) != 0) r.hold_class = $urandom_range(1) ? CLASS_SORTED : CLASS_FIFO;
    if ($urandom_range(1) != 0) r.run_length = 16'($urandom_range(7));
    return r;
  endfunction

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Request driver, which also drives the output ready.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid || in_acc) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor, predictor and checker.
  always @(posedge clk) begin
    jas_out_t want;
    if (rst) begin
      in_acc <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (in_valid && in_ready) schedule_job(in_data);
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: outcome=%0d job=%0d free=%0d last=%0b",
                     out_data.outcome, out_data.job_id, out_data.free_memory, out_data.last);
        end else begin
          want = predicted_results.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected outcome=%0d job=%0d free=%0d last=%0b,",
                       want.outcome, want.job_id, want.free_memory, want.last,
                       " got outcome=%0d job=%0d free=%0d last=%0b",
                       out_data.outcome, out_data.job_id, out_data.free_memory, out_data.last);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_requests.size() > 0 || in_valid || predicted_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [7:0] idx, logic [9:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == IDX_MEMORY) sys_memory = value;
    else if (idx == IDX_DEVICES) sys_devices = value[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) pending_requests.push_back(random_request());
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_acc = 1'b0;
    sys_memory = '0;
    sys_devices = '0;
    sorted_n = 0;
    fifo_n = 0;
    ready_n = 0;
    mem_in_use = '0;
    mismatches = 0;
    send_idle_pct = 17;
    recv_idle_pct = 76;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_register(IDX_MEMORY, 10'd600);
    write_register(IDX_DEVICES, 10'd200);
    write_register(IDX_UNUSED, 10'h3FF);
    // Directed: rejections in check order, a blocked sorted head with the FIFO
    // queue still draining, run-length ties, and a finish on an empty ready queue.
    pending_requests.push_back(make_request(OP_FINISH, 8'hFF, 10'h3FF, 8'hFF, 16'hFFFF, 2'd3));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd1, 10'd1023, 8'd255, 16'd0, 2'd0));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd2, 10'd10, 8'd255, 16'd0, 2'd0));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd3, 10'd10, 8'd0, 16'd0, 2'd0));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd4, 10'd10, 8'd0, 16'd0, 2'd3));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd5, 10'd400, 8'd200, 16'd9, CLASS_SORTED));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd6, 10'd300, 8'd1, 16'd5, CLASS_SORTED));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd7, 10'd100, 8'd1, 16'hFFFF, CLASS_FIFO));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd8, 10'd0, 8'd1, 16'd5, CLASS_SORTED));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd9, 10'd600, 8'd1, 16'd0, CLASS_SORTED));
    pending_requests.push_back(make_request(OP_ARRIVE, 8'd10, 10'd50, 8'd2, 16'd5, CLASS_SORTED));
    for (int i = 0; i < 6; i++)
      pending_requests.push_back(make_request(OP_FINISH, 8'(i), 10'd0, 8'd0, 16'd0, 2'd0));
    // Zero-memory jobs, all admitted to the ready queue.
    for (int i = 0; i < 10; i++)
      pending_requests.push_back(make_request(OP_ARRIVE, 8'(100 + i), 10'd0, 8'd0,
                                              16'(i % 3), CLASS_SORTED));
    wait_idle();
    // The sender stays paused here until every predicted result has come.
    for (int i = 0; i < 40; i++)
      pending_requests.push_back(make_request(OP_ARRIVE, 8'(150 + i), 10'd0, 8'd0,
                                              16'd7, (i < 20) ? CLASS_FIFO : CLASS_SORTED));
    wait_idle();

    write_register(IDX_MEMORY, 10'd1023);
    write_register(IDX_DEVICES, 10'd255);
    for (int i = 0; i < 45; i++)
      pending_requests.push_back(make_request(OP_FINISH, 8'd0, 10'd0, 8'd0, 16'd0, 2'd0));
    random_phase(30);

    send_idle_pct = 76;
    recv_idle_pct = 17;
    write_register(IDX_MEMORY, 10'd150);
    write_register(IDX_DEVICES, 10'd20);
    random_phase(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(IDX_MEMORY, 10'd0);
    write_register(IDX_DEVICES, 10'd0);
    random_phase(10);
    write_register(IDX_MEMORY, 10'd300);
    write_register(IDX_DEVICES, 10'd100);
    random_phase(30);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/jas_pkg.sv
rtl/jas_ctrl.sv
rtl/jas_datapath.sv
rtl/job_admission_scheduler.sv
test/tb_job_admission_scheduler.sv
